>>> rtl/mrh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the relative heading unit.
// No dependencies; every other file imports this package.
package mrh_pkg;

   // Field widths
   localparam int IN_W   = 16;
   localparam int OFS_W  = 13;
   localparam int OUT_W  = 16;

   // Algorithm parameters
   localparam int CORDIC_STEPS        = 16;
   localparam int ANGLE_FRACTION_BITS = 7;
   localparam int ACC_BITS            = 16;
   localparam int TABLE_LEN           = 24;
   localparam int STAGES = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   // Internal widths: vector grows by about 1.65 * sqrt(2); angle in 1/65536 degree
   localparam int XY_W   = IN_W + 4;
   localparam int ZW     = 26;
   localparam int HEAD_W = (ANGLE_FRACTION_BITS + 10 > OUT_W) ?
                           (ANGLE_FRACTION_BITS + 10) : (OUT_W + 1);
   localparam int ROUND_SHIFT = ACC_BITS - ANGLE_FRACTION_BITS;

   // Half turn in output units and in accumulator units
   localparam int HALF_UNIT = 180 << ANGLE_FRACTION_BITS;
   localparam int HALF_TURN = 180 << ACC_BITS;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_OFFSET = 1'b1;

   // Reset values of the offsets
   localparam logic signed [OFS_W-1:0] X_OFFSET_RESET = -13'sd20;
   localparam logic signed [OFS_W-1:0] Y_OFFSET_RESET = 13'sd26;

   // round(atan(2^-i) * 65536) degrees
   localparam int ATAN_TABLE [TABLE_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   // One item in flight through the rotation stages
   typedef struct packed {
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [ZW-1:0]     z;
      logic                     special;
      logic signed [HEAD_W-1:0] spec_head;
   } cordic_data_type;

   // Clip a one-bit-grown difference back to the sample width
   function automatic logic signed [IN_W-1:0] sat_in(input logic signed [IN_W:0] v);
      logic signed [IN_W-1:0] r;
      if (v[IN_W] != v[IN_W-1]) begin
         r = v[IN_W] ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
      end else begin
         r = v[IN_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/mrh_front.sv
`timescale 1ns / 1ps
// Front end: offset removal with saturation, then quadrant and axis handling.
// Depends on mrh_pkg.
module mrh_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [mrh_pkg::IN_W-1:0]       x_raw,
   input  logic signed [mrh_pkg::IN_W-1:0]       y_raw,
   input  logic signed [mrh_pkg::OFS_W-1:0]      x_offset,
   input  logic signed [mrh_pkg::OFS_W-1:0]      y_offset,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output mrh_pkg::cordic_data_type              out_data
);
   import mrh_pkg::*;

   localparam logic signed [HEAD_W-1:0] HALF_H    = HEAD_W'(HALF_UNIT);
   localparam logic signed [HEAD_W-1:0] QUARTER_H = HEAD_W'(HALF_UNIT / 2);
   localparam logic signed [ZW-1:0]     HALF_Z    = ZW'(HALF_TURN);

   logic                   a_valid_ff, a_valid_in, a_ready;
   logic signed [IN_W-1:0] ax_ff, ay_ff, ax_in, ay_in;
   logic                   b_valid_ff, b_valid_in, b_ready;
   cordic_data_type        b_data_ff, b_data_in;
   logic signed [IN_W:0]   x_diff, y_diff;

   // Stage ready: empty, or the next stage takes its item
   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   // Subtract offsets and clip to the sample range
   always_comb begin
      x_diff = (IN_W+1)'(x_raw) - (IN_W+1)'(x_offset);
      y_diff = (IN_W+1)'(y_raw) - (IN_W+1)'(y_offset);
      ax_in  = sat_in(x_diff);
      ay_in  = sat_in(y_diff);
      a_valid_in = in_valid;
   end

   // Resolve axes directly; turn the left half plane by 180 degrees
   always_comb begin
      b_valid_in          = a_valid_ff;
      b_data_in.x         = XY_W'(ax_ff);
      b_data_in.y         = XY_W'(ay_ff);
      b_data_in.z         = '0;
      b_data_in.special   = 1'b0;
      b_data_in.spec_head = '0;
      if (ay_ff == '0) begin
         b_data_in.special   = 1'b1;
         b_data_in.spec_head = ax_ff[IN_W-1] ? HALF_H : '0;
      end else if (ax_ff == '0) begin
         b_data_in.special   = 1'b1;
         b_data_in.spec_head = ay_ff[IN_W-1] ? -QUARTER_H : QUARTER_H;
      end else if (ax_ff[IN_W-1]) begin
         b_data_in.z = ay_ff[IN_W-1] ? -HALF_Z : HALF_Z;
         b_data_in.x = -XY_W'(ax_ff);
         b_data_in.y = -XY_W'(ay_ff);
      end
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= a_valid_in;
         if (b_ready) b_valid_ff <= b_valid_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (a_ready) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
      if (b_ready) b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

>>> rtl/mrh_cordic.sv
`timescale 1ns / 1ps
// Vectoring rotation pipeline: one register stage per micro-rotation.
// Depends on mrh_pkg.
module mrh_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  mrh_pkg::cordic_data_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mrh_pkg::cordic_data_type out_data
);
   import mrh_pkg::*;

   logic            valid_ff [STAGES];
   cordic_data_type data_ff  [STAGES];
   logic            stage_valid [STAGES];
   cordic_data_type stage_src   [STAGES];
   logic [STAGES:0] rdy;

   assign rdy[STAGES] = out_ready;
   assign in_ready    = rdy[0];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic signed [XY_W-1:0] xs, ys;
      logic signed [ZW-1:0]   atan_k;
      cordic_data_type        nxt;

      // Chain input from the previous stage
      if (k == 0) begin : g_first
         assign stage_valid[k] = in_valid;
         assign stage_src[k]   = in_data;
      end else begin : g_rest
         assign stage_valid[k] = valid_ff[k-1];
         assign stage_src[k]   = data_ff[k-1];
      end

      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      // Rotate toward the x axis and accumulate the angle
      always_comb begin
         xs     = stage_src[k].x >>> k;
         ys     = stage_src[k].y >>> k;
         atan_k = ZW'(ATAN_TABLE[k]);
         nxt    = stage_src[k];
         if (stage_src[k].y > 0) begin
            nxt.x = stage_src[k].x + ys;
            nxt.y = stage_src[k].y - xs;
            nxt.z = stage_src[k].z + atan_k;
         end else begin
            nxt.x = stage_src[k].x - ys;
            nxt.y = stage_src[k].y + xs;
            nxt.z = stage_src[k].z - atan_k;
         end
      end

      // Advance valid
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= stage_valid[k];
         end
      end

      // Advance payload
      always_ff @(posedge clock) begin
         if (rdy[k]) data_ff[k] <= nxt;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = data_ff[STAGES-1];

endmodule

>>> rtl/mrh_back.sv
`timescale 1ns / 1ps
// Back end: round and clamp the angle, hold the reference, form the relative angle.
// Depends on mrh_pkg.
module mrh_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  mrh_pkg::cordic_data_type         in_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [mrh_pkg::OUT_W-1:0] rsp_relative_angle,
   output logic signed [mrh_pkg::OUT_W-1:0] rsp_absolute_heading
);
   import mrh_pkg::*;

   localparam logic signed [ZW-1:0]     HALF_Z     = ZW'(HALF_UNIT);
   localparam logic signed [ZW-1:0]     ROUND_BIAS = ZW'(1 << (ROUND_SHIFT - 1));
   localparam logic signed [HEAD_W:0]   HALF_D     = (HEAD_W+1)'(HALF_UNIT);
   localparam logic signed [HEAD_W:0]   TURN_D     = (HEAD_W+1)'(2 * HALF_UNIT);

   logic                     r_valid_ff, r_ready;
   logic signed [HEAD_W-1:0] r_head_ff, r_head_in;
   logic signed [ZW-1:0]     z_sum, z_round;
   logic                     o_valid_ff, o_valid_in, o_ready;
   logic signed [HEAD_W-1:0] o_rel_ff, o_abs_ff;
   logic signed [HEAD_W:0]   diff;
   logic                     ref_valid_ff;
   logic signed [HEAD_W-1:0] ref_head_ff;

   assign o_ready  = !o_valid_ff || !rsp_stall;
   assign r_ready  = !r_valid_ff || o_ready;
   assign in_ready = r_ready;

   // Round to output units and clamp to a half turn
   always_comb begin
      z_sum   = in_data.z + ROUND_BIAS;
      z_round = z_sum >>> ROUND_SHIFT;
      if (z_round > HALF_Z) z_round = HALF_Z;
      if (z_round < -HALF_Z) z_round = -HALF_Z;
      r_head_in = in_data.special ? in_data.spec_head : z_round[HEAD_W-1:0];
   end

   // Heading minus reference, wrapped once into (-half, half]
   always_comb begin
      diff = (HEAD_W+1)'(r_head_ff) - (HEAD_W+1)'(ref_head_ff);
      if (diff <= -HALF_D) begin
         diff = diff + TURN_D;
      end else if (diff > HALF_D) begin
         diff = diff - TURN_D;
      end
      o_valid_in = r_valid_ff && ref_valid_ff;
   end

   // Advance control state; the first transaction only captures the reference
   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
         ref_valid_ff <= 1'b0;
         ref_head_ff  <= '0;
      end else begin
         if (r_ready) r_valid_ff <= in_valid;
         if (o_ready) begin
            o_valid_ff <= o_valid_in;
            if (r_valid_ff && !ref_valid_ff) begin
               ref_valid_ff <= 1'b1;
               ref_head_ff  <= r_head_ff;
            end
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (r_ready) r_head_ff <= r_head_in;
      if (o_ready) begin
         o_rel_ff <= diff[HEAD_W-1:0];
         o_abs_ff <= r_head_ff;
      end
   end

   assign rsp_valid            = o_valid_ff;
   assign rsp_relative_angle   = o_rel_ff[OUT_W-1:0];
   assign rsp_absolute_heading = o_abs_ff[OUT_W-1:0];

endmodule

>>> rtl/magnetometer_relative_heading_unit.sv
`timescale 1ns / 1ps
// Relative compass heading from two magnetometer axes. Each transaction carries one
// signed X and Y sample; the hard-iron offsets (register 0 for X, 1 for Y) are
// subtracted with saturation, and the heading atan2(y, x) is found by a 16-step
// vectoring CORDIC in 1/128 degree. The first transaction after reset sets the
// reference and returns nothing; every later one returns its heading and the heading
// minus the reference, wrapped into (-180, 180]. One transaction is taken per cycle
// unless stalled results have filled the pipeline, which has two front-end stages, one
// stage per CORDIC step, and rounding and output stages. Bubbles collapse, so a stalled
// result does not block intake until the pipeline is full. Write the offsets only while the unit is idle.
// Depends on mrh_pkg, mrh_front, mrh_cordic, mrh_back.
module magnetometer_relative_heading_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mrh_pkg::IN_W-1:0]      req_x_raw,
   input  logic signed [mrh_pkg::IN_W-1:0]      req_y_raw,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mrh_pkg::OUT_W-1:0]     rsp_relative_angle,
   output logic signed [mrh_pkg::OUT_W-1:0]     rsp_absolute_heading,
   input  logic                                 csr_write_enable,
   input  logic [mrh_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic signed [mrh_pkg::OFS_W-1:0]     csr_write_data
);
   import mrh_pkg::*;

   logic signed [OFS_W-1:0] x_offset_ff, y_offset_ff;
   logic                    front_ready, front_valid;
   cordic_data_type         front_data;
   logic                    cordic_ready, cordic_valid;
   cordic_data_type         cordic_data;
   logic                    back_ready;

   // Offset registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff <= X_OFFSET_RESET;
         y_offset_ff <= Y_OFFSET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_X_OFFSET: x_offset_ff <= csr_write_data;
            CSR_Y_OFFSET: y_offset_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_stall = !front_ready;

   mrh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .x_raw     (req_x_raw),
      .y_raw     (req_y_raw),
      .x_offset  (x_offset_ff),
      .y_offset  (y_offset_ff),
      .out_valid (front_valid),
      .out_ready (cordic_ready),
      .out_data  (front_data)
   );

   mrh_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (cordic_ready),
      .in_data   (front_data),
      .out_valid (cordic_valid),
      .out_ready (back_ready),
      .out_data  (cordic_data)
   );

   mrh_back u_back (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (cordic_valid),
      .in_ready             (back_ready),
      .in_data              (cordic_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_relative_angle   (rsp_relative_angle),
      .rsp_absolute_heading (rsp_absolute_heading)
   );

endmodule

>>> rtl/mrh_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the relative heading unit, bound to its top level.
// Depends on mrh_pkg and magnetometer_relative_heading_unit.
module mrh_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_stall,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [mrh_pkg::OUT_W-1:0] rsp_relative_angle,
   input  logic signed [mrh_pkg::OUT_W-1:0] rsp_absolute_heading
);
   import mrh_pkg::*;

   localparam logic signed [OUT_W-1:0] HALF_O = OUT_W'(HALF_UNIT);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_relative_angle) && $stable(rsp_absolute_heading)))
      else $error("result changed while stalled");

   // Intake is open whenever the output side can drain
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled with output free");

   // Relative angle stays within (-half turn, half turn]
   a_rel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_relative_angle > -HALF_O && rsp_relative_angle <= HALF_O))
      else $error("relative angle out of range");

   // Heading stays within [-half turn, half turn]
   a_abs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_absolute_heading >= -HALF_O && rsp_absolute_heading <= HALF_O))
      else $error("heading out of range");

   // Nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind magnetometer_relative_heading_unit mrh_checker u_mrh_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_relative_angle   (rsp_relative_angle),
   .rsp_absolute_heading (rsp_absolute_heading)
);

>>> test/magnetometer_relative_heading_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for magnetometer_relative_heading_unit: a directed table, then random
// samples under several hard-iron offset settings, checked against an in-bench CORDIC model.
// Depends on mrh_pkg and the RTL of the unit.
module magnetometer_relative_heading_unit_tb;
   import mrh_pkg::*;

   localparam int STEPS        = 16;
   localparam int FRAC_BITS    = 7;
   localparam int ROUND_SH     = 16 - FRAC_BITS;
   localparam int UNIT_HALF    = 180 << FRAC_BITS;
   localparam int ACC_HALF     = 180 << 16;
   localparam int PIPE_LATENCY = 20;
   localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
   localparam int RANDOM_COUNT = 110;
   localparam int PHASE_COUNT  = 7;
   localparam int STEADY_PHASE = 3;
   localparam int MAX_REPORTS  = 10;

   // round(atan(2^-i) * 65536) degrees
   localparam int ATAN_DEG [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [OUT_W-1:0] rel_angle;
      logic signed [OUT_W-1:0] abs_heading;
   } heading_type;

   typedef struct packed {
      logic signed [IN_W-1:0] x_raw;
      logic signed [IN_W-1:0] y_raw;
      logic                   typed;
      heading_type            want;
   } sample_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [IN_W-1:0]   req_x_raw = '0;
   logic signed [IN_W-1:0]   req_y_raw = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]  rsp_relative_angle;
   logic signed [OUT_W-1:0]  rsp_absolute_heading;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_X_OFFSET;
   logic signed [OFS_W-1:0]  csr_write_data = '0;

   // bench copy of the unit's configuration and reference state
   int             x_offset_cur = -20;
   int             y_offset_cur = 26;
   logic           ref_valid = 1'b0;
   int             ref_heading = 0;
   logic           steady_run = 1'b0;
   int             mismatch_count = 0;
   heading_type    heading_q [$];
   sample_row_type directed_rows [$];

   magnetometer_relative_heading_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_x_raw            (req_x_raw),
      .req_y_raw            (req_y_raw),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_relative_angle   (rsp_relative_angle),
      .rsp_absolute_heading (rsp_absolute_heading),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clip an offset-corrected sample to 16 bits
   function automatic int clip_sample(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Vectoring CORDIC heading in 1/128 degree
   function automatic int compute_heading(input int xv, input int yv);
      int x, y, z, xs, ys, r;
      x = xv;
      y = yv;
      z = 0;
      if (y == 0) return (x < 0) ? UNIT_HALF : 0;
      if (x == 0) return (y > 0) ? (UNIT_HALF / 2) : -(UNIT_HALF / 2);
      // turn the left half plane by a half turn first
      if (x < 0) begin
         z = (y >= 0) ? ACC_HALF : -ACC_HALF;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_DEG[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_DEG[i];
         end
      end
      r = (z + (1 << (ROUND_SH - 1))) >>> ROUND_SH;
      if (r > UNIT_HALF) r = UNIT_HALF;
      if (r < -UNIT_HALF) r = -UNIT_HALF;
      return r;
   endfunction

   // Advance the model by one accepted transaction; queue the result it causes
   function automatic void predict_sample(input logic signed [IN_W-1:0] xr,
                                          input logic signed [IN_W-1:0] yr,
                                          input logic typed, input heading_type typed_val);
      int h, d;
      heading_type res;
      h = compute_heading(clip_sample(int'(xr) - x_offset_cur),
                          clip_sample(int'(yr) - y_offset_cur));
      if (!ref_valid) begin
         ref_valid = 1'b1;
         ref_heading = h;
         return;
      end
      d = h - ref_heading;
      if (d <= -UNIT_HALF) d = d + 2 * UNIT_HALF;
      else if (d > UNIT_HALF) d = d - 2 * UNIT_HALF;
      res.rel_angle = d[OUT_W-1:0];
      res.abs_heading = h[OUT_W-1:0];
      heading_q.push_back(typed ? typed_val : res);
   endfunction

   function automatic void add_row(input int xr, input int yr, input logic typed,
                                   input int rel, input int hd);
      sample_row_type row;
      row.x_raw = xr[IN_W-1:0];
      row.y_raw = yr[IN_W-1:0];
      row.typed = typed;
      row.want.rel_angle = rel[OUT_W-1:0];
      row.want.abs_heading = hd[OUT_W-1:0];
      directed_rows.push_back(row);
   endfunction

   // Random sample, weighted toward axes, the origin and the saturation corners
   function automatic void pick_sample(output logic signed [IN_W-1:0] xr,
                                       output logic signed [IN_W-1:0] yr);
      int mode;
      mode = $urandom_range(99);
      xr = IN_W'($urandom);
      yr = IN_W'($urandom);
      if (mode >= 55 && mode < 70) begin
         if ($urandom_range(1)) xr = x_offset_cur[IN_W-1:0];
         else yr = y_offset_cur[IN_W-1:0];
      end else if (mode >= 70 && mode < 82) begin
         xr = IN_W'(x_offset_cur + int'($urandom_range(16)) - 8);
         yr = IN_W'(y_offset_cur + int'($urandom_range(16)) - 8);
      end else if (mode >= 82 && mode < 94) begin
         xr = ($urandom_range(1) ? 16'sh7FFF : 16'sh8000) ^ 16'($urandom_range(3));
         yr = ($urandom_range(1) ? 16'sh7FFF : 16'sh8000) ^ 16'($urandom_range(3));
      end else if (mode >= 94) begin
         xr = x_offset_cur[IN_W-1:0];
         yr = y_offset_cur[IN_W-1:0];
      end
   endfunction

   // Offer one transaction, with random idle cycles ahead of it outside the steady phase, and hold it until taken
   task automatic send_sample(input logic signed [IN_W-1:0] xr,
                              input logic signed [IN_W-1:0] yr,
                              input logic typed, input heading_type typed_val);
      while (!steady_run && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_raw <= xr;
      req_y_raw <= yr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sample(xr, yr, typed, typed_val);
   endtask

   // Drop valid, wait for every queued result, then let the pipeline empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (heading_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both offsets on back-to-back cycles; only called while the unit is idle
   task automatic set_offsets(input int xo, input int yo);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_X_OFFSET;
      csr_write_data <= xo[OFS_W-1:0];
      @(posedge clock);
      x_offset_cur = xo;
      csr_index <= CSR_Y_OFFSET;
      csr_write_data <= yo[OFS_W-1:0];
      @(posedge clock);
      y_offset_cur = yo;
      csr_write_enable <= 1'b0;
   endtask

   // Random result stall outside the steady phase, and compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      heading_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.rel_angle = rsp_relative_angle;
         got.abs_heading = rsp_absolute_heading;
         if (heading_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: rel %0d abs %0d",
                        got.rel_angle, got.abs_heading);
         end else begin
            want = heading_q.pop_front();
            if (got.rel_angle !== want.rel_angle || got.abs_heading !== want.abs_heading) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result mismatch: expected rel %0d abs %0d, got rel %0d abs %0d",
                           want.rel_angle, want.abs_heading,
                           got.rel_angle, got.abs_heading);
            end
         end
      end
      rsp_stall <= !steady_run && ($urandom_range(99) < 19);
   end

   initial begin : stimulus
      logic signed [IN_W-1:0] xr, yr;
      heading_type            none;
      int                     xo, yo;
      none = '0;

      // Directed table, reset offsets (-20, 26); the first row sets a 90 degree reference
      add_row(   -20,    126, 1'b0,      0,      0);
      add_row(    80,     26, 1'b1, -11520,      0);
      add_row(  -120,     26, 1'b1,  11520,  23040);
      add_row(   -20,    126, 1'b1,      0,  11520);
      add_row(   -20,    -74, 1'b1,  23040, -11520);
      add_row(   -20,     26, 1'b1, -11520,      0);
      add_row( 32767,     26, 1'b1, -11520,      0);
      add_row(-32768,     26, 1'b1,  11520,  23040);
      add_row(   -20,  32767, 1'b1,      0,  11520);
      add_row(   -20, -32768, 1'b1,  23040, -11520);
      add_row( 32767,  32767, 1'b0,      0,      0);
      add_row(-32768, -32768, 1'b0,      0,      0);
      add_row(-32768,  32767, 1'b0,      0,      0);
      add_row( 32767, -32768, 1'b0,      0,      0);
      add_row(  -120,     27, 1'b0,      0,      0);
      add_row(  -120,     25, 1'b0,      0,      0);
      add_row(   -19,     27, 1'b0,      0,      0);
      add_row(   -21,     25, 1'b0,      0,      0);
      add_row(   -21,     27, 1'b0,      0,      0);
      add_row(   -19,     25, 1'b0,      0,      0);
      add_row(    80,   -500, 1'b0,      0,      0);
      add_row( -2000,  -1500, 1'b0,      0,      0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].x_raw, directed_rows[i].y_raw,
                     directed_rows[i].typed, directed_rows[i].want);

      // Random phases, each under its own offset setting
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            wait_drained();
            case (phase)
               1: begin xo = -4096; yo = -4096; end
               2: begin xo =  4095; yo =  4095; end
               3: begin xo = -4096; yo =  4095; end
               4: begin xo =     0; yo =     0; end
               default: begin
                  xo = int'($urandom_range(8191)) - 4096;
                  yo = int'($urandom_range(8191)) - 4096;
               end
            endcase
            set_offsets(xo, yo);
         end
         steady_run <= (phase == STEADY_PHASE);
         for (int n = 0; n < RANDOM_COUNT; n++) begin
            // hold off the sender until the unit has caught up
            if (phase != STEADY_PHASE && n != 0 &&
                (n == RANDOM_COUNT / 2 || $urandom_range(149) == 0))
               wait_drained();
            pick_sample(xr, yr);
            send_sample(xr, yr, 1'b0, none);
         end
      end

      wait_drained();
      if (mismatch_count == 0 && heading_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
